FILE: hdl/frwl_pkg.sv
// Package for the flash record wear leveler: sizes, register indexes,
// controller states and the byte mask helpers.
// No dependencies.
package frwl_pkg;

  localparam int SLOTS       = 16;
  localparam int ENTRY_BYTES = 8;
  localparam int NUM_ENTRIES = 2;
  localparam int NUM_WORDS   = NUM_ENTRIES * SLOTS;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int ADDR_W      = $clog2(NUM_WORDS);

  // Configuration register indexes.
  localparam logic [7:0] REG_DEFAULT_VALUE_A = 8'd0;
  localparam logic [7:0] REG_DEFAULT_SIZE_A  = 8'd1;
  localparam logic [7:0] REG_DEFAULT_VALUE_B = 8'd2;
  localparam logic [7:0] REG_DEFAULT_SIZE_B  = 8'd3;

  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INIT,
    ST_DECIDE,
    ST_ERASE,
    ST_PROG,
    ST_FINISH
  } frwl_state_t;

  // Mask that covers the low n bytes of a word; n of 8 or more covers all.
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < n) m[8*k +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // Byte counts above the entry size are taken as the entry size.
  function automatic logic [3:0] clamp_count(input logic [3:0] n);
    return (n > 4'(ENTRY_BYTES)) ? 4'(ENTRY_BYTES) : n;
  endfunction

  localparam logic [63:0] ENTRY_MASK = byte_mask(4'(ENTRY_BYTES));

  // Word left in an erased slot after programming the low n bytes of data.
  function automatic logic [63:0] program_word(input logic [63:0] data,
                                               input logic [3:0]  n);
    return data | ~byte_mask(clamp_count(n));
  endfunction

  // Flash word address of slot s of entry e.
  function automatic logic [ADDR_W-1:0] addr_of(input logic e,
                                                input logic [SLOT_W-1:0] s);
    return e ? (ADDR_W'(SLOTS) + ADDR_W'(s)) : ADDR_W'(s);
  endfunction

endpackage

FILE: hdl/flash_record_wear_leveler_unit.sv
// Top level of the flash record wear leveler: flash word memory, its
// erased-state valid bits and the scan and program controller.
// Depends on frwl_pkg.

// Each item takes one beat in and gives one beat out. The current slot is
// found by a backward scan through the flash memory's single read port, one
// slot per cycle. A write that runs past the last slot also scans the other
// entry and then erases and rewrites. A new item is taken only once the
// previous one is finished; its result may still wait in the output register.
// Erased flash is tracked by one valid bit per word, cleared at reset and by
// a sector erase, so no clearing pass is needed. Configuration writes are
// accepted in every cycle.
module flash_record_wear_leveler_unit
  import frwl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Request channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        entry_select,
  input  logic [63:0] new_value,
  input  logic [3:0]  byte_count,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] value,
  output logic [7:0]  slot,
  output logic        appended,
  output logic        erased,
  output logic        initialized
);

  // Configuration registers.
  logic [63:0] default_value_a;
  logic [3:0]  default_size_a;
  logic [63:0] default_value_b;
  logic [3:0]  default_size_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value_a <= '0;
      default_size_a  <= 4'd8;
      default_value_b <= '0;
      default_size_b  <= 4'd8;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEFAULT_VALUE_A: default_value_a <= cfg_data;
        REG_DEFAULT_SIZE_A:  default_size_a  <= cfg_data[3:0];
        REG_DEFAULT_VALUE_B: default_value_b <= cfg_data;
        REG_DEFAULT_SIZE_B:  default_size_b  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Flash memory with one write and one registered read port.
  logic [63:0]          mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld;
  logic [NUM_WORDS-1:0] vld_next;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_wa;
  logic [63:0]          mem_wd;
  logic                 vld_clr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [63:0]          rd_q;
  logic                 rd_v;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[rd_addr];
  end

  // An erase clears every valid bit; a write in the same cycle sets its own.
  always_comb begin
    vld_next = vld_clr ? '0 : vld;
    if (mem_we) vld_next[mem_wa] = 1'b1;
  end

  // A word whose valid bit is clear reads as erased flash.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rd_v <= 1'b0;
    end else begin
      vld  <= vld_next;
      rd_v <= vld[rd_addr];
    end
  end

  logic [63:0] rd_word;
  logic        rd_blank;
  assign rd_word  = rd_v ? rd_q : '1;
  assign rd_blank = (rd_word & ENTRY_MASK) == ENTRY_MASK;

  // Controller registers.
  frwl_state_t       state, state_next;
  logic              phase, phase_next;
  logic              req_write, req_ent;
  logic [63:0]       req_data;
  logic [3:0]        req_cnt;
  logic [SLOT_W-1:0] sidx, sidx_next;
  logic              s_more, s_more_next;
  logic              chk, chk_next;
  logic [SLOT_W-1:0] chk_idx, chk_idx_next;
  logic [SLOT_W-1:0] p_slot, p_slot_next;
  logic [63:0]       p_word, p_word_next;
  logic [63:0]       o_word, o_word_next;
  logic              init_flag, init_flag_next;
  logic [63:0]       res_value, res_value_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic              res_app, res_app_next;
  logic              res_era, res_era_next;
  logic              out_load;

  logic              scan_ent;
  logic [63:0]       def_word_p;
  logic [63:0]       def_word_o;
  logic [63:0]       wr_mask;
  logic              need_move;

  assign in_ready = (state == ST_IDLE);
  assign scan_ent = phase ? ~req_ent : req_ent;

  // Default words of the addressed and the other entry.
  assign def_word_p = req_ent ? program_word(default_value_b, default_size_b)
                              : program_word(default_value_a, default_size_a);
  assign def_word_o = req_ent ? program_word(default_value_a, default_size_a)
                              : program_word(default_value_b, default_size_b);

  // A write must move when it would raise a bit that is already cleared.
  assign wr_mask   = byte_mask(req_cnt);
  assign need_move = |((req_data & wr_mask) & ~p_word);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= 1'b0;
      s_more    <= 1'b0;
      chk       <= 1'b0;
      init_flag <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      s_more    <= s_more_next;
      chk       <= chk_next;
      init_flag <= init_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_write <= (action == ACT_WRITE);
      req_ent   <= entry_select;
      req_data  <= new_value;
      req_cnt   <= clamp_count(byte_count);
    end
    sidx      <= sidx_next;
    chk_idx   <= chk_idx_next;
    p_slot    <= p_slot_next;
    p_word    <= p_word_next;
    o_word    <= o_word_next;
    res_value <= res_value_next;
    res_slot  <= res_slot_next;
    res_app   <= res_app_next;
    res_era   <= res_era_next;
  end

  // Next state, memory accesses and result staging.
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    sidx_next      = sidx;
    s_more_next    = s_more;
    chk_next       = chk;
    chk_idx_next   = chk_idx;
    p_slot_next    = p_slot;
    p_word_next    = p_word;
    o_word_next    = o_word;
    init_flag_next = init_flag;
    res_value_next = res_value;
    res_slot_next  = res_slot;
    res_app_next   = res_app;
    res_era_next   = res_era;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    vld_clr        = 1'b0;
    rd_addr        = '0;
    out_load       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          phase_next     = 1'b0;
          sidx_next      = SLOT_W'(SLOTS - 1);
          s_more_next    = 1'b1;
          chk_next       = 1'b0;
          init_flag_next = 1'b0;
          res_app_next   = 1'b0;
          res_era_next   = 1'b0;
          state_next     = ST_SCAN;
        end
      end

      // Backward scan: issue one slot a cycle, check the word read before.
      ST_SCAN: begin
        rd_addr = addr_of(scan_ent, sidx);
        if (s_more) begin
          chk_next     = 1'b1;
          chk_idx_next = sidx;
          if (sidx == '0) s_more_next = 1'b0;
          else sidx_next = sidx - 1'b1;
        end else begin
          chk_next = 1'b0;
        end
        if (chk) begin
          if (!rd_blank) begin
            chk_next    = 1'b0;
            s_more_next = 1'b0;
            if (!phase) begin
              p_slot_next = chk_idx;
              p_word_next = rd_word;
              state_next  = ST_DECIDE;
            end else begin
              o_word_next = rd_word;
              state_next  = ST_ERASE;
            end
          end else if (chk_idx == '0) begin
            // Blank region: the entry's default becomes its value.
            chk_next    = 1'b0;
            s_more_next = 1'b0;
            if (!phase) begin
              p_slot_next = '0;
              p_word_next = def_word_p;
              state_next  = ST_INIT;
            end else begin
              o_word_next = def_word_o;
              state_next  = ST_ERASE;
            end
          end
        end
      end

      ST_INIT: begin
        mem_we         = 1'b1;
        mem_wa         = addr_of(req_ent, '0);
        mem_wd         = p_word;
        init_flag_next = 1'b1;
        state_next     = ST_DECIDE;
      end

      ST_DECIDE: begin
        if (!req_write) begin
          res_value_next = p_word;
          res_slot_next  = p_slot;
          state_next     = ST_FINISH;
        end else if (!need_move) begin
          // Program over the current slot.
          mem_we         = 1'b1;
          mem_wa         = addr_of(req_ent, p_slot);
          mem_wd         = p_word & (req_data | ~wr_mask);
          res_value_next = mem_wd;
          res_slot_next  = p_slot;
          state_next     = ST_FINISH;
        end else if (p_slot != SLOT_W'(SLOTS - 1)) begin
          // The next slot is still erased.
          mem_we         = 1'b1;
          mem_wa         = addr_of(req_ent, p_slot + 1'b1);
          mem_wd         = req_data | ~wr_mask;
          res_value_next = mem_wd;
          res_slot_next  = p_slot + 1'b1;
          res_app_next   = 1'b1;
          state_next     = ST_FINISH;
        end else begin
          // Region full: find the other entry's value before the erase.
          phase_next  = 1'b1;
          sidx_next   = SLOT_W'(SLOTS - 1);
          s_more_next = 1'b1;
          chk_next    = 1'b0;
          state_next  = ST_SCAN;
        end
      end

      // Erase the sector and rewrite the other entry at its first slot.
      ST_ERASE: begin
        vld_clr    = 1'b1;
        mem_we     = 1'b1;
        mem_wa     = addr_of(~req_ent, '0);
        mem_wd     = o_word | ~ENTRY_MASK;
        state_next = ST_PROG;
      end

      ST_PROG: begin
        mem_we         = 1'b1;
        mem_wa         = addr_of(req_ent, '0);
        mem_wd         = req_data | ~wr_mask;
        res_value_next = mem_wd;
        res_slot_next  = '0;
        res_app_next   = 1'b1;
        res_era_next   = 1'b1;
        state_next     = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value       <= res_value;
      slot        <= 8'(res_slot);
      appended    <= res_app;
      erased      <= res_era;
      initialized <= init_flag;
    end
  end

endmodule
